// ===== hdl/skf_pkg.sv =====
// Shared constants, types and control codes for the scalar Kalman filter core.
`timescale 1ns / 1ps
`default_nettype none

package skf_pkg;

   // Input sample and fixed-point scaling
   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 16;

   // Fixed field widths
   localparam int EST_W     = 32;
   localparam int COV_W     = 32;
   localparam int NOISE_W   = 32;
   localparam int GAIN_FRAC = 16;
   localparam int GAIN_W    = GAIN_FRAC + 1;

   // Derived datapath widths
   localparam int SCALED_W = SAMPLE_BITS + FRAC_BITS;
   localparam int DIFF_W   = ((SCALED_W > EST_W) ? SCALED_W : EST_W) + 1;
   localparam int ACC_W    = DIFF_W + 1;
   localparam int CORR_W   = ACC_W + 1;
   localparam int SUM_W    = CORR_W + 1;

   // Gain of exactly 1.0 in Q1.16
   localparam logic [GAIN_W-1:0] GAIN_ONE = {1'b1, {GAIN_FRAC{1'b0}}};

   // Serial step counts
   localparam int DIV_STEPS = GAIN_FRAC;
   localparam int MUL_STEPS = GAIN_W;
   localparam int CNT_W     = $clog2(MUL_STEPS);

   // Register map
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_PROCESS_NOISE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEASURE_NOISE = 2'd1;

   localparam logic [NOISE_W-1:0] PROCESS_NOISE_RESET = 32'd655;
   localparam logic [NOISE_W-1:0] MEASURE_NOISE_RESET = 32'd65536;

   // Sequencer strobes to the serial units
   typedef struct packed {
      logic load;
      logic step;
   } skf_ctrl_type;

endpackage

`default_nettype wire

// ===== hdl/skf_channels.sv =====
// Valid/ready channel interfaces: sample request, result, register write.
`timescale 1ns / 1ps
`default_nettype none

interface skf_req_if import skf_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface skf_rsp_if import skf_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [EST_W-1:0] estimate;
   logic [GAIN_W-1:0]       gain;
   modport source (output valid, output estimate, output gain, input ready);
   modport sink   (input valid, input estimate, input gain, output ready);
endinterface

interface skf_csr_if import skf_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [NOISE_W-1:0]   data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/skf_gain_div.sv =====
// Radix-2 restoring divider for the gain, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module skf_gain_div import skf_pkg::*; (
   input  wire logic               clock,
   input  wire skf_ctrl_type       ctrl,
   input  wire logic [COV_W-1:0]   prior,
   input  wire logic [NOISE_W-1:0] measure_noise,
   output logic [GAIN_W-1:0]       gain
);

   logic [COV_W:0]     rem_ff, rem_in;
   logic [COV_W:0]     den_ff, den_in;
   logic [GAIN_FRAC-1:0] quo_ff, quo_in;
   logic               full_ff, full_in;

   logic [COV_W+1:0]   rem_shift;
   logic [COV_W+2:0]   diff;
   logic               fits;

   // Trial subtract of the doubled remainder; remainder stays below the divisor
   always_comb begin
      rem_shift = {rem_ff, 1'b0};
      diff      = {1'b0, rem_shift} - {2'b00, den_ff};
      fits      = !diff[COV_W+2];
   end

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      full_in = full_ff;
      if (ctrl.load) begin
         // prior < prior + R whenever R is non-zero, so the top quotient bit is zero
         rem_in  = {1'b0, prior};
         den_in  = {1'b0, prior} + {1'b0, measure_noise};
         quo_in  = '0;
         full_in = (measure_noise == '0);
      end else if (ctrl.step) begin
         rem_in = fits ? diff[COV_W:0] : rem_shift[COV_W:0];
         quo_in = {quo_ff[GAIN_FRAC-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      full_ff <= full_in;
   end

   // Zero R gives a gain of one (also covers a zero denominator)
   assign gain = full_ff ? GAIN_ONE : {1'b0, quo_ff};

endmodule

`default_nettype wire

// ===== hdl/skf_update_mul.sv =====
// Bit-serial shift-add multipliers for the estimate correction and the new covariance.
`timescale 1ns / 1ps
`default_nettype none

module skf_update_mul import skf_pkg::*; (
   input  wire logic                       clock,
   input  wire skf_ctrl_type               ctrl,
   input  wire logic signed [SCALED_W-1:0] scaled,
   input  wire logic signed [EST_W-1:0]    estimate,
   input  wire logic [COV_W-1:0]           prior,
   input  wire logic [GAIN_W-1:0]          gain,
   output logic signed [CORR_W-1:0]        correction,
   output logic [COV_W-1:0]                covariance
);

   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic [GAIN_W-1:0]        mk_ff, mk_in;
   logic [GAIN_W-1:0]        gk_ff, gk_in;
   logic [COV_W-1:0]         prior_ff, prior_in;
   logic signed [ACC_W-1:0]  acc_e_ff, acc_e_in;
   logic [COV_W:0]           acc_p_ff, acc_p_in;
   logic                     lo_e_ff, lo_e_in;
   logic                     lo_p_ff, lo_p_in;

   logic signed [ACC_W-1:0]  add_e;
   logic [COV_W:0]           add_p;

   // Partial-product adds; accumulators stay within one bit of the multiplicand
   always_comb begin
      add_e = acc_e_ff + (mk_ff[0] ? ACC_W'(diff_ff) : ACC_W'(0));
      add_p = acc_p_ff + (gk_ff[0] ? {1'b0, prior_ff} : {(COV_W+1){1'b0}});
   end

   always_comb begin
      diff_in  = diff_ff;
      mk_in    = mk_ff;
      gk_in    = gk_ff;
      prior_in = prior_ff;
      acc_e_in = acc_e_ff;
      acc_p_in = acc_p_ff;
      lo_e_in  = lo_e_ff;
      lo_p_in  = lo_p_ff;
      if (ctrl.load) begin
         diff_in  = DIFF_W'(scaled) - DIFF_W'(estimate);
         mk_in    = gain;
         gk_in    = GAIN_ONE - gain;
         prior_in = prior;
         acc_e_in = '0;
         acc_p_in = '0;
         lo_e_in  = 1'b0;
         lo_p_in  = 1'b0;
      end else if (ctrl.step) begin
         // Shift right; the last bit shifted out is product bit GAIN_FRAC
         acc_e_in = {add_e[ACC_W-1], add_e[ACC_W-1:1]};
         lo_e_in  = add_e[0];
         acc_p_in = {1'b0, add_p[COV_W:1]};
         lo_p_in  = add_p[0];
         mk_in    = {1'b0, mk_ff[GAIN_W-1:1]};
         gk_in    = {1'b0, gk_ff[GAIN_W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      diff_ff  <= diff_in;
      mk_ff    <= mk_in;
      gk_ff    <= gk_in;
      prior_ff <= prior_in;
      acc_e_ff <= acc_e_in;
      acc_p_ff <= acc_p_in;
      lo_e_ff  <= lo_e_in;
      lo_p_ff  <= lo_p_in;
   end

   // Products shifted down by GAIN_FRAC, floor rounding for both signs
   assign correction = $signed({acc_e_ff, lo_e_ff});
   assign covariance = {acc_p_ff[COV_W-2:0], lo_p_ff};

endmodule

`default_nettype wire

// ===== hdl/scalar_kalman_filter_core.sv =====
// Top level of the scalar Kalman filter: sequencer, state, registers and result stage.
//
//   Channel  Port     Direction  Payload                 Transfer
//   -------  -------  ---------  ----------------------  -------------------
//   request  req_bus  in         sample                  valid && ready
//   result   rsp_bus  out        estimate, gain          valid && ready
//   config   csr_bus  in         index, data             valid (ready tied 1)
//
// For one request, the prior covariance is registered on the accepting edge; then
// come a divider load, 16 divider steps (one gain bit each), a multiplier load, 17
// shift-add steps (one gain bit each) and the update. The next request is taken the
// cycle after the update. Reset is synchronous and active high; it restores both
// noise registers and clears the estimate and covariance. A stalled result holds
// in its output register while the next request is accepted; the update cycle
// waits for it.
`timescale 1ns / 1ps
`default_nettype none

module scalar_kalman_filter_core import skf_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   skf_req_if.sink     req_bus,
   skf_rsp_if.source   rsp_bus,
   skf_csr_if.sink     csr_bus
);

   // Sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PREP  = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_SETUP = 3'd3;
   localparam logic [2:0] ST_MUL   = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);
   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS - 1);

   localparam logic signed [EST_W-1:0] EST_MAX = {1'b0, {(EST_W-1){1'b1}}};
   localparam logic signed [EST_W-1:0] EST_MIN = {1'b1, {(EST_W-1){1'b0}}};

   logic [2:0]                    state_ff, state_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [NOISE_W-1:0]            process_noise_ff, process_noise_in;
   logic [NOISE_W-1:0]            measure_noise_ff, measure_noise_in;
   logic signed [EST_W-1:0]       est_ff, est_in;
   logic [COV_W-1:0]              cov_ff, cov_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [COV_W-1:0]              prior_ff, prior_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [EST_W-1:0]       rsp_est_ff, rsp_est_in;
   logic [GAIN_W-1:0]             rsp_gain_ff, rsp_gain_in;

   skf_ctrl_type                  div_ctrl;
   skf_ctrl_type                  mul_ctrl;
   logic [GAIN_W-1:0]             gain;
   logic signed [CORR_W-1:0]      correction;
   logic [COV_W-1:0]              new_cov;
   logic signed [SCALED_W-1:0]    scaled;
   logic [COV_W:0]                prior_sum;
   logic [COV_W-1:0]              prior_sat;
   logic signed [SUM_W-1:0]       est_sum;
   logic signed [EST_W-1:0]       new_est;
   logic                          req_take;
   logic                          rsp_free;
   logic                          csr_take;

   // Handshakes
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign csr_take      = csr_bus.valid;
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;

   // Prior covariance, saturated
   always_comb begin
      prior_sum = {1'b0, cov_ff} + {1'b0, process_noise_ff};
      prior_sat = prior_sum[COV_W] ? {COV_W{1'b1}} : prior_sum[COV_W-1:0];
   end

   // Sample scaled into fixed point
   assign scaled = $signed({sample_ff, {FRAC_BITS{1'b0}}});

   // New estimate, saturated to the signed range
   always_comb begin
      est_sum = SUM_W'(est_ff) + SUM_W'(correction);
      if (!est_sum[SUM_W-1] && (est_sum[SUM_W-2:EST_W-1] != '0)) begin
         new_est = EST_MAX;
      end else if (est_sum[SUM_W-1] && (est_sum[SUM_W-2:EST_W-1] != '1)) begin
         new_est = EST_MIN;
      end else begin
         new_est = est_sum[EST_W-1:0];
      end
   end

   // Strobes to the serial units
   always_comb begin
      div_ctrl.load = (state_ff == ST_PREP);
      div_ctrl.step = (state_ff == ST_DIV);
      mul_ctrl.load = (state_ff == ST_SETUP);
      mul_ctrl.step = (state_ff == ST_MUL);
   end

   // Sequencer, state update and result register
   always_comb begin
      state_in         = state_ff;
      cnt_in           = cnt_ff;
      process_noise_in = process_noise_ff;
      measure_noise_in = measure_noise_ff;
      est_in           = est_ff;
      cov_in           = cov_ff;
      sample_in        = sample_ff;
      prior_in         = prior_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_bus.ready;
      rsp_est_in       = rsp_est_ff;
      rsp_gain_in      = rsp_gain_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               sample_in = req_bus.sample;
               prior_in  = prior_sat;
               state_in  = ST_PREP;
            end
         end
         ST_PREP: begin
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cnt_in   = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == MUL_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               est_in       = new_est;
               cov_in       = new_cov;
               rsp_valid_in = 1'b1;
               rsp_est_in   = new_est;
               rsp_gain_in  = gain;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Register writes; any known register also clears the filter state
      if (csr_take) begin
         priority case (csr_bus.index)
            CSR_PROCESS_NOISE: begin
               process_noise_in = csr_bus.data;
               est_in           = '0;
               cov_in           = '0;
            end
            CSR_MEASURE_NOISE: begin
               measure_noise_in = csr_bus.data;
               est_in           = '0;
               cov_in           = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         cnt_ff           <= '0;
         process_noise_ff <= PROCESS_NOISE_RESET;
         measure_noise_ff <= MEASURE_NOISE_RESET;
         est_ff           <= '0;
         cov_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         cnt_ff           <= cnt_in;
         process_noise_ff <= process_noise_in;
         measure_noise_ff <= measure_noise_in;
         est_ff           <= est_in;
         cov_ff           <= cov_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      prior_ff    <= prior_in;
      rsp_est_ff  <= rsp_est_in;
      rsp_gain_ff <= rsp_gain_in;
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.estimate = rsp_est_ff;
   assign rsp_bus.gain     = rsp_gain_ff;

   skf_gain_div u_gain_div (
      .clock         (clock),
      .ctrl          (div_ctrl),
      .prior         (prior_ff),
      .measure_noise (measure_noise_ff),
      .gain          (gain)
   );

   skf_update_mul u_update_mul (
      .clock      (clock),
      .ctrl       (mul_ctrl),
      .scaled     (scaled),
      .estimate   (est_ff),
      .prior      (prior_ff),
      .gain       (gain),
      .correction (correction),
      .covariance (new_cov)
   );

endmodule

`default_nettype wire

// ===== hdl/skf_checker.sv =====
// Port-level assertions for the scalar Kalman filter core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module skf_checker import skf_pkg::*; (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_valid,
   input wire logic                    req_ready,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic signed [EST_W-1:0] rsp_estimate,
   input wire logic [GAIN_W-1:0]       rsp_gain
);

   // Gain never exceeds one
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_gain <= GAIN_ONE))
      else $error("gain above 1.0");

   // A request occupies the core: no second request right after one
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while busy");

   // A result never appears in the cycle after a request is taken
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("result without serial work");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_estimate) && $stable(rsp_gain)))
      else $error("stalled result changed");

endmodule

bind scalar_kalman_filter_core skf_checker u_skf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_estimate (rsp_bus.estimate),
   .rsp_gain     (rsp_bus.gain)
);

`default_nettype wire
